FILE: hdl/uartfc_pkg.sv
// Shared types, codes and constants for the UART with receive FIFO and flow control.
package uartfc_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  localparam logic [15:0] TICKS_RESET   = 16'd1388;
  localparam logic [6:0]  RTS_THR_RESET = 7'd48;
  localparam logic [15:0] MIN_FRAME     = 16'd40;

  // Receive timing runs in units of 1/80 tick, transmit timing in 1/10 tick.
  localparam int RX_W = 23;
  localparam int TX_W = 20;
  localparam logic [RX_W-1:0] RX_ACC_INIT  = RX_W'(79);
  localparam logic [RX_W-1:0] RX_ACC_STEP  = RX_W'(80);
  localparam logic [RX_W-1:0] RX_FIRST_OFS = RX_W'(43);
  localparam logic [TX_W-1:0] TX_ACC_INIT  = TX_W'(4);
  localparam logic [TX_W-1:0] TX_ACC_STEP  = TX_W'(10);

  localparam logic [3:0] RX_LAST_DATA = 4'd8;
  localparam logic [3:0] RX_STOP_BIT  = 4'd9;
  localparam logic [3:0] TX_BITS      = 4'd10;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_TICKS   = 3'd0,
    CFG_RTS_THR = 3'd1,
    CFG_RTS_EN  = 3'd2,
    CFG_CTS_EN  = 3'd3,
    CFG_NEG     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TX_IDLE    = 2'd0,
    TX_PENDING = 2'd1,
    TX_SENDING = 2'd2
  } tx_state_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_BAD_START = 3'd2;
  localparam logic [2:0] ERR_BAD_STOP  = 3'd3;
  localparam logic [2:0] ERR_LOST      = 3'd4;

  // One classified tick as it waits in the queue.
  typedef struct packed {
    logic       rd;
    logic       pop;
    logic       wr;
    logic [7:0] tx_data;
    logic       rxd;
    logic       cts;
  } item_t;

  // Bit timing derived from the frame length.
  typedef struct packed {
    logic [15:0]     frame;
    logic [RX_W-1:0] rx_stop;
  } timing_t;

  typedef struct packed {
    logic [6:0] rts_thr;
    logic       rts_en;
    logic       cts_en;
    logic       neg;
  } flow_cfg_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic       write_accepted;
    logic       tx_busy;
    logic [5:0] fill_count;
    logic       read_valid;
    logic [7:0] read_data;
    logic       rts_out;
    logic       txd;
  } result_t;

endpackage

FILE: hdl/uart_8n1_with_fifo_and_flow_control.sv
// Top level: configuration registers, bit-timing setup and the front/engine pair.
//
//  channel  direction  handshake           payload
//  in_      slave      in_tvalid/tready    tdata 16b (byte, rxd, cts), tuser 2b (operation)
//  out_     master     out_tvalid/tready   tdata 24b (pins, read result, fill, status)
//  cfg_     slave      cfg_valid/ready     cfg_index 3b, cfg_data 16b
//
// One tick per clock while out_tready is high; a result passes through the queue and then
// the engine and its result register before it is offered.
// The rate is set by the engine, which updates all receive and transmit state together.
// Reset is synchronous on rst_n; the FIFO memory is not cleared, only its pointers.
// A two-entry queue sits before the engine and a result register after it; when out_tready
// is low with a result waiting the engine holds, and in_tready drops once both entries are
// taken. cfg_ready is always high.
module uart_8n1_with_fifo_and_flow_control #(
  parameter int FIFO_DEPTH = uartfc_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_data[7:0], rxd[8], cts_in[9], zero pad [15:10]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // txd[0], rts_out[1], read_data[9:2], read_valid[10],
                                  // fill_count[16:11], tx_busy[17], write_accepted[18],
                                  // error_code[21:19], zero pad [23:22]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import uartfc_pkg::*;

  logic [15:0] ticks_r;
  flow_cfg_t   flow_r;
  timing_t     tim_r;
  logic [15:0] f_eff;
  logic        q_valid, q_ready;
  item_t       q_item;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r        <= TICKS_RESET;
      flow_r.rts_thr <= RTS_THR_RESET;
      flow_r.rts_en  <= 1'b0;
      flow_r.cts_en  <= 1'b0;
      flow_r.neg     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TICKS:   ticks_r        <= cfg_data;
        CFG_RTS_THR: flow_r.rts_thr <= cfg_data[6:0];
        CFG_RTS_EN:  flow_r.rts_en  <= cfg_data[0];
        CFG_CTS_EN:  flow_r.cts_en  <= cfg_data[0];
        CFG_NEG:     flow_r.neg     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stop-bit sample target in 1/80 tick: 73F; data bit i sits at 4F(2i+1)+43.
  assign f_eff = (ticks_r < MIN_FRAME) ? MIN_FRAME : ticks_r;

  always_ff @(posedge clk) begin
    tim_r.frame   <= f_eff;
    tim_r.rx_stop <= RX_W'({f_eff, 6'd0}) + RX_W'({f_eff, 3'd0}) + RX_W'(f_eff);
  end

  uartfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  uartfc_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .tim       (tim_r),
    .flow      (flow_r),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  assign out_tdata = {2'b00, res.error_code, res.write_accepted, res.tx_busy, res.fill_count,
                      res.read_valid, res.read_data, res.rts_out, res.txd};

endmodule

FILE: hdl/uartfc_front.sv
// Input side: accepts ticks, decodes the host operation and queues them for the engine.
module uartfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // tx_data[7:0], rxd[8], cts_in[9], zero pad
  input  logic [1:0]           in_tuser,   // operation[1:0]
  output logic                 q_valid,
  output uartfc_pkg::item_t    q_item,
  input  logic                 q_ready
);
  import uartfc_pkg::*;

  item_t      q_r [2];
  logic       wr_idx_r, rd_idx_r;
  logic [1:0] count_r;
  logic       push, pop;
  item_t      dec;
  op_t        op;

  assign op = op_t'(in_tuser);

  always_comb begin
    dec.rd      = 1'b0;
    dec.pop     = 1'b0;
    dec.wr      = 1'b0;
    dec.tx_data = in_tdata[7:0];
    dec.rxd     = in_tdata[8];
    dec.cts     = in_tdata[9];
    case (op)
      OP_READ: begin
        dec.rd  = 1'b1;
        dec.pop = 1'b1;
      end
      OP_PEEK:  dec.rd = 1'b1;
      OP_WRITE: dec.wr = 1'b1;
      default: ;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = q_r[rd_idx_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_idx_r <= ~wr_idx_r;
      if (pop)  rd_idx_r <= ~rd_idx_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hdl/uartfc_back.sv
// Engine: host operations, transmitter, receiver, receive FIFO memory and result register.
module uartfc_back #(
  parameter int FIFO_DEPTH = uartfc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  uartfc_pkg::item_t     q_item,
  output logic                  q_ready,
  input  uartfc_pkg::timing_t   tim,
  input  uartfc_pkg::flow_cfg_t flow,
  output logic                  out_valid,
  output uartfc_pkg::result_t   out_res,
  input  logic                  out_ready
);
  import uartfc_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int FW = (PW > 7) ? PW : 7;
  localparam logic [PW:0]   DEPTH_V = (PW+1)'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(FIFO_DEPTH - 1);

  // FIFO memory and pointers
  logic [7:0]    mem [FIFO_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [7:0]    head_q_r, byp_data_r, head;
  logic          byp_r;
  logic          we;
  logic [7:0]    wdata;

  // receiver
  logic [9:0]      rx_shift_r, rx_shift_nxt;
  logic [RX_W-1:0] rx_acc_r, rx_acc_nxt;
  logic [3:0]      rx_bit_r, rx_bit_nxt;
  logic            rx_active_r, rx_active_nxt;
  logic            rx_prev_r, rx_prev_nxt;

  // transmitter
  tx_state_t       tx_state_r, tx_state_nxt;
  logic [9:0]      tx_shift_r, tx_shift_nxt;
  logic [TX_W-1:0] tx_acc_r, tx_acc_nxt;
  logic [3:0]      tx_bit_r, tx_bit_nxt;
  logic            lost_r, lost_nxt;
  logic [2:0]      err_r, err_nxt;

  logic    fire;
  result_t res, out_res_r;
  logic    out_valid_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_P) ? '0 : p + PW'(1);
  endfunction

  assign q_ready = !out_valid_r || out_ready;
  assign fire    = q_valid && q_ready;
  assign head    = byp_r ? byp_data_r : head_q_r;

  always_comb begin
    logic            cts_ok;
    logic            rx_fall;
    logic            rts_asserted;
    logic [PW:0]     fill_w;
    logic [FW-1:0]   fill_ext;
    logic [RX_W-3:0] rx_prod;
    logic [RX_W-1:0] rx_tgt;
    logic [TX_W-1:0] tx_tgt;

    tx_state_nxt  = tx_state_r;
    tx_shift_nxt  = tx_shift_r;
    tx_acc_nxt    = tx_acc_r;
    tx_bit_nxt    = tx_bit_r;
    lost_nxt      = lost_r;
    err_nxt       = err_r;
    rx_shift_nxt  = rx_shift_r;
    rx_acc_nxt    = rx_acc_r;
    rx_bit_nxt    = rx_bit_r;
    rx_active_nxt = rx_active_r;
    rx_prev_nxt   = rx_prev_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    we            = 1'b0;
    wdata         = rx_shift_r[9:2];
    cts_ok        = 1'b0;
    rx_fall       = 1'b0;
    res           = '0;
    res.txd       = 1'b1;

    // targets of the current bits follow the frame length as it stands now;
    // the stop bit is sampled early, at its own fixed fraction
    rx_prod = (RX_W-2)'(tim.frame) * (RX_W-2)'({rx_bit_r, 1'b1});
    rx_tgt  = (rx_bit_r >= RX_STOP_BIT) ? tim.rx_stop : RX_W'({rx_prod, 2'b00}) + RX_FIRST_OFS;
    tx_tgt  = TX_W'(tim.frame) * TX_W'({1'b0, tx_bit_r} + 5'd1);

    if (fire) begin
      // host operation
      if (q_item.rd) begin
        if (rp_r != wp_r) begin
          res.read_data  = head;
          res.read_valid = 1'b1;
          if (q_item.pop) rp_nxt = ptr_inc(rp_r);
        end
      end else if (q_item.wr && tx_state_r == TX_IDLE) begin
        tx_shift_nxt       = {1'b1, q_item.tx_data, 1'b0};
        tx_state_nxt       = TX_PENDING;
        res.write_accepted = 1'b1;
      end

      // transmitter
      case (tx_state_nxt)
        TX_SENDING: begin
          tx_acc_nxt = tx_acc_r + TX_ACC_STEP;
          if (tx_acc_nxt >= tx_tgt) begin
            tx_bit_nxt = tx_bit_r + 4'd1;
            if (tx_bit_nxt >= TX_BITS) begin
              tx_state_nxt = TX_IDLE;
              tx_bit_nxt   = 4'd0;
              if (lost_r) err_nxt = ERR_LOST;
              lost_nxt = 1'b0;
            end
          end
        end
        TX_PENDING: begin
          cts_ok = !flow.cts_en || (q_item.cts ^ flow.neg);
          if (cts_ok && !rx_active_r) begin
            tx_state_nxt = TX_SENDING;
            tx_acc_nxt   = TX_ACC_INIT;
            tx_bit_nxt   = 4'd0;
          end
        end
        default: ;
      endcase
      if (tx_state_nxt == TX_SENDING) res.txd = tx_shift_nxt[tx_bit_nxt];

      // receiver; it never runs while a frame is being sent
      rx_fall = rx_prev_r && !q_item.rxd;
      if (tx_state_nxt == TX_SENDING) begin
        if (rx_fall && !rx_active_r) lost_nxt = 1'b1;
      end else if (!rx_active_r) begin
        if (rx_fall) begin
          rx_active_nxt = 1'b1;
          rx_acc_nxt    = RX_ACC_INIT;
          rx_bit_nxt    = 4'd0;
          rx_shift_nxt  = '0;
        end
      end else begin
        rx_acc_nxt = rx_acc_r + RX_ACC_STEP;
        if (rx_acc_nxt >= rx_tgt) begin
          rx_shift_nxt = {q_item.rxd, rx_shift_r[9:1]};
          if (rx_bit_r == RX_LAST_DATA) begin
            we     = 1'b1;
            wdata  = rx_shift_nxt[9:2];
            wp_nxt = ptr_inc(wp_r);
            if (wp_nxt == rp_nxt) err_nxt = ERR_OVERFLOW;
          end
          if (rx_bit_r >= RX_STOP_BIT) begin
            if (rx_shift_nxt[0] && err_nxt == ERR_NONE) err_nxt = ERR_BAD_START;
            if (!rx_shift_nxt[9]) err_nxt = ERR_BAD_STOP;
            rx_active_nxt = 1'b0;
            rx_bit_nxt    = 4'd0;
          end else begin
            rx_bit_nxt = rx_bit_r + 4'd1;
          end
        end
      end
      rx_prev_nxt = q_item.rxd;
    end

    // outputs
    fill_w   = {1'b0, wp_nxt} - {1'b0, rp_nxt} + ((wp_nxt < rp_nxt) ? DEPTH_V : '0);
    fill_ext = FW'(fill_w[PW-1:0]);
    if (!flow.rts_en) begin
      rts_asserted = 1'b1;
    end else if (tx_state_nxt == TX_SENDING) begin
      rts_asserted = 1'b0;
    end else begin
      rts_asserted = (fill_ext < FW'(flow.rts_thr));
    end
    res.rts_out    = rts_asserted ^ flow.neg;
    res.fill_count = fill_ext[5:0];
    res.tx_busy    = (tx_state_nxt != TX_IDLE);
    res.error_code = err_nxt;
  end

  // receive FIFO memory; read data is registered, with a bypass for a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp_r] <= wdata;
    end
    head_q_r   <= mem[rp_nxt];
    byp_r      <= we && (wp_r == rp_nxt);
    byp_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_state_r  <= TX_IDLE;
      tx_bit_r    <= 4'd0;
      lost_r      <= 1'b0;
      err_r       <= ERR_NONE;
      rx_bit_r    <= 4'd0;
      rx_active_r <= 1'b0;
      rx_prev_r   <= 1'b1;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tx_state_r  <= tx_state_nxt;
      tx_bit_r    <= tx_bit_nxt;
      lost_r      <= lost_nxt;
      err_r       <= err_nxt;
      rx_bit_r    <= rx_bit_nxt;
      rx_active_r <= rx_active_nxt;
      rx_prev_r   <= rx_prev_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      if (q_ready) out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    tx_shift_r <= tx_shift_nxt;
    tx_acc_r   <= tx_acc_nxt;
    rx_shift_r <= rx_shift_nxt;
    rx_acc_r   <= rx_acc_nxt;
    if (fire) out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: test/uart_8n1_with_fifo_and_flow_control_tb.sv
// Testbench for the 8N1 UART with receive FIFO and RTS/CTS flow control.
`timescale 1ns / 1ps

module uart_8n1_with_fifo_and_flow_control_tb;
  import uartfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  // One pin sample plus host operation, as it enters the block.
  typedef struct {
    op_t        op;
    logic [7:0] data;
    logic       rxd;
    logic       cts;
  } pin_tick_t;

  // Cycle-exact mirror of the transceiver; queues the result of every transfer taken.
  class uart_pin_mirror;
    logic [7:0]  rx_store [64];
    logic [5:0]  wr_ptr, rd_ptr;
    logic [9:0]  rx_bits;
    logic [15:0] rx_ticks;
    logic [3:0]  rx_idx;
    logic        rx_busy, rx_last;
    logic [9:0]  tx_bits;
    logic [15:0] tx_ticks;
    logic [3:0]  tx_idx;
    tx_state_t   tx_mode;
    logic [2:0]  err;
    logic        rx_lost;
    logic [15:0] frame_reg;
    logic [6:0]  rts_thr;
    logic        rts_en, cts_en, neg;
    result_t     results_due[$];
    int unsigned bad_count, seen;

    function new();
      foreach (rx_store[i]) rx_store[i] = 8'h00;
      wr_ptr = '0;
      rd_ptr = '0;
      rx_bits = '0;
      rx_ticks = '0;
      rx_idx = '0;
      rx_busy = 1'b0;
      rx_last = 1'b1;
      tx_bits = '0;
      tx_ticks = '0;
      tx_idx = '0;
      tx_mode = TX_IDLE;
      err = ERR_NONE;
      rx_lost = 1'b0;
      frame_reg = TICKS_RESET;
      rts_thr = RTS_THR_RESET;
      rts_en = 1'b0;
      cts_en = 1'b0;
      neg = 1'b0;
      bad_count = 0;
      seen = 0;
    endfunction

    function int unsigned frame_len();
      return (frame_reg < MIN_FRAME) ? MIN_FRAME : frame_reg;
    endfunction

    // Sample point of receive bit i, in ticks after the falling edge; stop bit early.
    function int unsigned rx_due(logic [3:0] i);
      if (i >= RX_STOP_BIT) return frame_len() * 73 / 80;
      return (frame_len() * (2 * i + 1) + 10) / 20;
    endfunction

    function int unsigned tx_end(logic [3:0] i);
      return (frame_len() * (i + 1) + 5) / 10;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_TICKS:   frame_reg = v;
        CFG_RTS_THR: rts_thr = v[6:0];
        CFG_RTS_EN:  rts_en = v[0];
        CFG_CTS_EN:  cts_en = v[0];
        CFG_NEG:     neg = v[0];
        default: ;
      endcase
    endfunction

    function void take_tick(pin_tick_t t);
      result_t    r;
      logic       fall, rts;
      logic [5:0] fill;
      r = '0;
      r.txd = 1'b1;

      // host side
      if (t.op == OP_READ || t.op == OP_PEEK) begin
        if (rd_ptr != wr_ptr) begin
          r.read_data = rx_store[rd_ptr];
          r.read_valid = 1'b1;
          if (t.op == OP_READ) rd_ptr = rd_ptr + 1'b1;
        end
      end else if (t.op == OP_WRITE && tx_mode == TX_IDLE) begin
        tx_bits = {1'b1, t.data, 1'b0};
        tx_mode = TX_PENDING;
        r.write_accepted = 1'b1;
      end

      // transmitter
      if (tx_mode == TX_SENDING) begin
        tx_ticks = tx_ticks + 1'b1;
        if (tx_ticks >= tx_end(tx_idx)) begin
          tx_idx = tx_idx + 1'b1;
          if (tx_idx >= TX_BITS) begin
            tx_mode = TX_IDLE;
            tx_idx = '0;
            if (rx_lost) err = ERR_LOST;
            rx_lost = 1'b0;
          end
        end
      end else if (tx_mode == TX_PENDING) begin
        if ((!cts_en || (t.cts ^ neg)) && !rx_busy) begin
          tx_mode = TX_SENDING;
          tx_ticks = '0;
          tx_idx = '0;
        end
      end
      if (tx_mode == TX_SENDING) r.txd = tx_bits[tx_idx];

      // receiver: a falling edge during transmit only marks the frame as lost
      fall = rx_last && !t.rxd;
      if (tx_mode == TX_SENDING) begin
        if (fall && !rx_busy) rx_lost = 1'b1;
      end else if (!rx_busy) begin
        if (fall) begin
          rx_busy = 1'b1;
          rx_ticks = '0;
          rx_idx = '0;
          rx_bits = '0;
        end
      end else begin
        rx_ticks = rx_ticks + 1'b1;
        if (rx_ticks >= rx_due(rx_idx)) begin
          rx_bits = {t.rxd, rx_bits[9:1]};
          if (rx_idx == RX_LAST_DATA) begin
            rx_store[wr_ptr] = rx_bits[9:2];
            wr_ptr = wr_ptr + 1'b1;
            if (wr_ptr == rd_ptr) err = ERR_OVERFLOW;
          end
          if (rx_idx >= RX_STOP_BIT) begin
            if (rx_bits[0] && err == ERR_NONE) err = ERR_BAD_START;
            if (!rx_bits[9]) err = ERR_BAD_STOP;
            rx_busy = 1'b0;
            rx_idx = '0;
          end else begin
            rx_idx = rx_idx + 1'b1;
          end
        end
      end
      rx_last = t.rxd;

      fill = wr_ptr - rd_ptr;
      if (!rts_en) rts = 1'b1;
      else if (tx_mode == TX_SENDING) rts = 1'b0;
      else rts = ({1'b0, fill} < rts_thr);
      r.rts_out = rts ^ neg;
      r.fill_count = fill;
      r.tx_busy = (tx_mode != TX_IDLE);
      r.error_code = err;
      results_due.push_back(r);
    endfunction

    function void match_result(logic [23:0] word);
      result_t exp, got;
      got = result_t'(word[21:0]);
      seen++;
      if (results_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("result %0d: %h arrived with nothing due", seen, word);
        return;
      end
      exp = results_due.pop_front();
      if (word[23:22] !== 2'b00 || got.txd !== exp.txd || got.rts_out !== exp.rts_out ||
          got.read_data !== exp.read_data || got.read_valid !== exp.read_valid ||
          got.fill_count !== exp.fill_count || got.tx_busy !== exp.tx_busy ||
          got.write_accepted !== exp.write_accepted || got.error_code !== exp.error_code) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("result %0d: exp txd=%b rts=%b rdata=%h rvalid=%b fill=%0d busy=%b wacc=%b err=%0d",
                   seen, exp.txd, exp.rts_out, exp.read_data, exp.read_valid, exp.fill_count,
                   exp.tx_busy, exp.write_accepted, exp.error_code);
          $display("  got txd=%b rts=%b rdata=%h rvalid=%b fill=%0d busy=%b wacc=%b err=%0d pad=%b",
                   got.txd, got.rts_out, got.read_data, got.read_valid, got.fill_count,
                   got.tx_busy, got.write_accepted, got.error_code, word[23:22]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  uart_pin_mirror mirror;
  int unsigned    cycle_count = 0;

  // pacing and operation mix
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned read_pct = 0, peek_pct = 0, write_pct = 0, quiet_ticks = 0;
  logic        cts_lvl = 1'b0;

  // receive line generator
  int unsigned cur_frame = TICKS_RESET;
  int unsigned ln_tick = 0, ln_len = 0, ln_gap = 0, long_gap_pct = 10;
  logic [9:0]  ln_bits = '1;
  bit          ln_busy = 0, ln_noise = 0, ln_glitch = 0, force_bad_start = 0;

  uart_8n1_with_fifo_and_flow_control u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uart_8n1_with_fifo_and_flow_control test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.match_result(out_tdata);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Next RXD level: mostly clean frames, some with a glitched start, a low stop,
  // a cut-short stop, or plain noise.
  function automatic logic next_rxd();
    int unsigned kind, bidx;
    logic        lvl;
    if (!ln_busy) begin
      if (ln_gap != 0) begin
        ln_gap--;
        return 1'b1;
      end
      kind = $urandom_range(99);
      ln_busy = 1;
      ln_tick = 0;
      ln_len = cur_frame;
      ln_bits = {1'b1, 8'($urandom), 1'b0};
      ln_noise = 0;
      ln_glitch = force_bad_start;
      force_bad_start = 0;
      if (kind < 6) ln_glitch = 1;
      else if (kind < 12) ln_bits[9] = 1'b0;
      else if (kind < 20) begin
        ln_noise = 1;
        ln_len = $urandom_range(cur_frame, 1);
      end else if (kind < 32) ln_len = $urandom_range(cur_frame, cur_frame * 73 / 80);
    end
    if (ln_noise) begin
      lvl = 1'($urandom_range(1));
    end else begin
      bidx = ln_tick * 10 / cur_frame;
      if (bidx > 9) bidx = 9;
      lvl = ln_bits[bidx];
      if (ln_glitch && bidx == 0 && ln_tick != 0) lvl = 1'b1;
    end
    ln_tick++;
    if (ln_tick >= ln_len) begin
      ln_busy = 0;
      if ($urandom_range(99) < long_gap_pct) ln_gap = $urandom_range(3 * cur_frame, 5);
      else ln_gap = $urandom_range(3);
    end
    return lvl;
  endfunction

  function automatic pin_tick_t make_tick();
    pin_tick_t   t;
    int unsigned r;
    r = $urandom_range(99);
    if (r < read_pct) t.op = OP_READ;
    else if (r < read_pct + peek_pct) t.op = OP_PEEK;
    else if (r < read_pct + peek_pct + write_pct && quiet_ticks == 0) t.op = OP_WRITE;
    else t.op = OP_NONE;
    if (quiet_ticks != 0) quiet_ticks--;
    case ($urandom_range(7))
      0: t.data = 8'h00;
      1: t.data = 8'hFF;
      default: t.data = 8'($urandom);
    endcase
    if ($urandom_range(7) == 0) cts_lvl = ~cts_lvl;
    t.cts = cts_lvl;
    t.rxd = next_rxd();
    return t;
  endfunction

  function automatic pin_tick_t pin(op_t op, logic [7:0] data, logic rxd, logic cts);
    pin_tick_t t;
    t.op = op;
    t.data = data;
    t.rxd = rxd;
    t.cts = cts;
    return t;
  endfunction

  task automatic send_tick(input pin_tick_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, t.cts, t.rxd, t.data};
    in_tuser  <= t.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_tick(t);
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) send_tick(make_tick());
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain(input int unsigned extra);
    in_tvalid <= 1'b0;
    while (mirror.results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] frame, input logic [15:0] thr,
                           input logic [15:0] rts, input logic [15:0] cts,
                           input logic [15:0] inv);
    cfg_idx_t    order [5] = '{CFG_TICKS, CFG_RTS_THR, CFG_RTS_EN, CFG_CTS_EN, CFG_NEG};
    logic [15:0] vals  [5];
    vals = '{frame, thr, rts, cts, inv};
    drain(4);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      mirror.set_reg(order[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    cur_frame = (frame < MIN_FRAME) ? MIN_FRAME : frame;
    // drop any frame in progress on the line
    ln_busy = 0;
    ln_gap = 0;
  endtask

  initial begin
    mirror = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame length below the minimum, CTS gating on; rxd held idle.
    load_regs(16'd0, 16'd64, 16'd1, 16'd1, 16'd0);
    send_tick(pin(OP_NONE,  8'h00, 1'b1, 1'b0));
    send_tick(pin(OP_READ,  8'hFF, 1'b1, 1'b1));  // empty read
    send_tick(pin(OP_PEEK,  8'h00, 1'b1, 1'b0));  // empty peek
    send_tick(pin(OP_WRITE, 8'hFF, 1'b1, 1'b0));  // taken, waits for CTS
    send_tick(pin(OP_WRITE, 8'h00, 1'b1, 1'b0));  // busy, dropped
    send_tick(pin(OP_NONE,  8'hAA, 1'b1, 1'b1));  // CTS up: start sending
    send_tick(pin(OP_PEEK,  8'h55, 1'b1, 1'b1));
    send_tick(pin(OP_WRITE, 8'h5A, 1'b1, 1'b1));  // dropped while sending
    send_tick(pin(OP_READ,  8'h00, 1'b1, 1'b0));
    send_tick(pin(OP_NONE,  8'hFF, 1'b1, 1'b1));
    cts_lvl = 1'b1;

    // Back-to-back transfers; open with a glitched start while the error is still clear.
    read_pct = 12;
    peek_pct = 6;
    write_pct = 10;
    force_bad_start = 1;
    ln_gap = 60;
    quiet_ticks = 150;
    run_ticks(300);

    // Inverted flow-control levels, threshold zero, sender mostly idle.
    load_regs(16'd39, 16'd0, 16'd1, 16'd1, 16'd1);
    idle_pct = 77;
    run_ticks(150);

    // Longest frame, upper bits set in each word but CTS enable, receiver mostly stalled.
    load_regs(16'hFFFF, 16'hFF40, 16'hFFFE, 16'h0000, 16'hFFFF);
    idle_pct = 0;
    stall_pct = 77;
    run_ticks(40);

    // No pops and no writes: let received bytes pile up in the FIFO past a low threshold.
    load_regs(16'd40, 16'd4, 16'd1, 16'd0, 16'd0);
    idle_pct = 10;
    stall_pct = 10;
    read_pct = 0;
    peek_pct = 5;
    write_pct = 0;
    long_gap_pct = 0;
    run_ticks(250);

    // RTS held, threshold above any fill, CTS active low.
    load_regs(16'($urandom_range(90, 40)), 16'd127, 16'd0, 16'd1, 16'd1);
    idle_pct = 0;
    stall_pct = 77;
    read_pct = 20;
    peek_pct = 8;
    write_pct = 12;
    long_gap_pct = 10;
    run_ticks(100);
    drain(0);
    run_ticks(100);

    load_regs(16'($urandom_range(120, 40)), 16'($urandom_range(64)), 16'd1,
              16'($urandom_range(1)), 16'($urandom_range(1)));
    idle_pct = 77;
    stall_pct = 0;
    read_pct = 15;
    run_ticks(150);

    drain(8);
    if (mirror.bad_count == 0) begin
      $display("uart_8n1_with_fifo_and_flow_control test passed");
    end else begin
      $display("uart_8n1_with_fifo_and_flow_control test failed");
    end
    $finish;
  end

endmodule
